[design/pfe_pkg.sv]
// Shared types, character codes, operation and status codes for the postfix evaluator.
package pfe_pkg;

  localparam int DATA_W          = 16;
  localparam int DEF_STACK_DEPTH = 16;
  localparam int CMDQ_DEPTH      = 4;
  localparam int CMDQ_AW         = $clog2(CMDQ_DEPTH);

  // ASCII codes
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;

  // Operation codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;
  localparam logic [2:0] OP_NE   = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  // One command from the front end to the execution unit
  typedef struct packed {
    logic              push;  // push num before applying op
    logic [DATA_W-1:0] num;
    logic [2:0]        op;
    logic              last;  // emit result after this command
  } cmd_t;

  // Map a character to its operation code
  function automatic logic [2:0] decode_op(input logic [7:0] ch);
    logic [2:0] op;
    unique case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_EQ:    op = OP_EQ;
      CH_BANG:  op = OP_NE;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

[design/pfe_front.sv]
// Front end: accepts characters, builds numbers and issues stack commands.
module pfe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  input  logic          cmdq_full,
  output logic          cmd_wr,
  output pfe_pkg::cmd_t cmd
);
  import pfe_pkg::*;

  logic [DATA_W-1:0] accum;
  logic              in_num;
  logic              accept;
  logic              is_digit;
  logic [2:0]        op;
  logic [DATA_W-1:0] accum_next;

  assign full     = cmdq_full;
  assign accept   = push && !cmdq_full;
  assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
  assign op       = decode_op(char_code);

  // accum * 10 + digit, wrapping at the data width
  assign accum_next = (accum << 3) + (accum << 1) + DATA_W'(char_code - CH_0);

  // Form the command for this beat
  always_comb begin
    cmd.last = last_char;
    if (is_digit) begin
      cmd.push = 1'b1;
      cmd.num  = accum_next;
      cmd.op   = OP_NONE;
      cmd_wr   = accept && last_char;
    end else begin
      cmd.push = in_num;
      cmd.num  = accum;
      cmd.op   = op;
      cmd_wr   = accept && (in_num || (op != OP_NONE) || last_char);
    end
  end

  // Advance the number builder
  always_ff @(posedge clk) begin
    if (rst) begin
      accum  <= '0;
      in_num <= 1'b0;
    end else if (accept) begin
      if (is_digit && !last_char) begin
        accum  <= accum_next;
        in_num <= 1'b1;
      end else begin
        accum  <= '0;
        in_num <= 1'b0;
      end
    end
  end

endmodule

[design/pfe_cmd_fifo.sv]
// Short command queue between the front end and the execution unit.
module pfe_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  pfe_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output pfe_pkg::cmd_t rdata
);
  import pfe_pkg::*;

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/pfe_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pfe_pkg::DATA_W-1:0] num,
  input  logic [pfe_pkg::DATA_W-1:0] den,
  output logic                      done,
  output logic [pfe_pkg::DATA_W-1:0] quot
);
  import pfe_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic [DATA_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DATA_W-1]};
  assign fits  = (trial >= {1'b0, dmag});
  assign quot  = neg ? (~quo + 1'b1) : quo;

  // Control: run DATA_W steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DATA_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring shift-subtract on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num[DATA_W-1] ? (~num + 1'b1) : num;
      dmag <= den[DATA_W-1] ? (~den + 1'b1) : den;
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      rem  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DATA_W'(trial - {1'b0, dmag});
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

[design/pfe_back.sv]
// Execution unit: operand stack, arithmetic, sticky errors and the result register.
module pfe_back #(
  parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmdq_empty,
  input  pfe_pkg::cmd_t                    cmd_in,
  output logic                             cmd_rd,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [pfe_pkg::DATA_W-1:0] value,
  output logic [1:0]                       status
);
  import pfe_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] top;
  logic [1:0]        err;
  logic              out_valid;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] second;
  logic              mem_we;
  logic              mem_re;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic [DATA_W-1:0] alu_r;
  logic [2*DATA_W-1:0] prod;

  assign cmd_rd = (state == S_IDLE) && !cmdq_empty;
  assign empty  = !out_valid;
  assign cnt_m1 = cnt - 1'b1;
  assign cnt_m2 = cnt - 2'd2;

  assign mem_we = (state == S_PUSH) && cmd.push && (cnt != '0)
                  && (cnt < CNT_W'(STACK_DEPTH));
  assign mem_re = (state == S_OP) && (cnt >= CNT_W'(2));

  assign div_start = (state == S_EXEC) && (cmd.op == OP_DIV) && (top != '0);

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[IDX_W-1:0]] <= top;
    end
    if (mem_re) begin
      second <= mem[cnt_m2[IDX_W-1:0]];
    end
  end

  pfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (second),
    .den   (top),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Combinational operators other than division
  assign prod = second * top;
  always_comb begin
    unique case (cmd.op)
      OP_ADD:  alu_r = second + top;
      OP_SUB:  alu_r = second - top;
      OP_MUL:  alu_r = prod[DATA_W-1:0];
      OP_EQ:   alu_r = DATA_W'(second == top);
      OP_NE:   alu_r = DATA_W'(second != top);
      default: alu_r = '0;
    endcase
  end

  // Sequence each command
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!cmdq_empty) begin
            cmd   <= cmd_in;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (cmd.push) begin
            if (cnt >= CNT_W'(STACK_DEPTH)) begin
              if (err == ST_OK) err <= ST_OVERFLOW;
            end else begin
              top <= cmd.num;
              cnt <= cnt + 1'b1;
            end
          end
          state <= (cmd.op != OP_NONE) ? S_OP : S_FIN;
        end
        S_OP: begin
          if (cnt < CNT_W'(2)) begin
            if (err == ST_OK) err <= ST_UNDERFLOW;
            state <= S_FIN;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.op == OP_DIV) begin
            if (top == '0) begin
              if (err == ST_OK) err <= ST_DIVZERO;
              top   <= '0;
              cnt   <= cnt_m1;
              state <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end else begin
            top   <= alu_r;
            cnt   <= cnt_m1;
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_quot;
            cnt   <= cnt_m1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!cmd.last) begin
            state <= S_IDLE;
          end else if (!out_valid) begin
            // Hold the result, then clear for the next expression
            out_valid <= 1'b1;
            value     <= (cnt != '0) ? top : '0;
            status    <= ((cnt == '0) && (err == ST_OK)) ? ST_UNDERFLOW : err;
            cnt       <= '0;
            err       <= ST_OK;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/postfix_expression_evaluator_core.sv]
// Top level of the postfix expression evaluator: front end, command queue, execution unit.
//
// Usage: feed an expression one ASCII character per beat on char_code, with
// last_char high on its final character. A beat is taken when push is high
// and full is low. Digits build unsigned numbers; + - * / = ! operate on the
// operand stack; anything else only ends a number. After the last character
// one result (value, status) appears while empty is low and leaves on pop.
// The front end handles a character in the beat it is taken. An operator
// runs through states idle, push, op, exec, fin; '/' also waits in div while
// the iterative divider resolves one quotient bit per cycle and sets the
// sustained rate for division-heavy input. A four-entry command queue
// lets the front end keep taking characters while the execution unit works.
// When the receiver stalls, the result waits in the output register and
// execution holds at the next final character; full rises once the queue
// fills. Reset (rst, synchronous) empties the queue and the stack, clears
// the pending number and the sticky error, and drops any waiting result.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        char_code,
  input  logic                              last_char,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pfe_pkg::DATA_W-1:0] value,
  output logic [1:0]                        status
);
  import pfe_pkg::*;

  cmd_t cmd_w;
  cmd_t cmd_r;
  logic cmd_wr;
  logic cmd_rd;
  logic cmdq_full;
  logic cmdq_empty;

  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last_char (last_char),
    .cmdq_full (cmdq_full),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd_w)
  );

  pfe_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_wr),
    .wdata (cmd_w),
    .full  (cmdq_full),
    .rd    (cmd_rd),
    .empty (cmdq_empty),
    .rdata (cmd_r)
  );

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmdq_empty (cmdq_empty),
    .cmd_in     (cmd_r),
    .cmd_rd     (cmd_rd),
    .empty      (empty),
    .pop        (pop),
    .value      (value),
    .status     (status)
  );

  // Queue never reports full and empty together
  a_q_consistent: assert property (@(posedge clk) disable iff (rst)
    !(cmdq_full && cmdq_empty))
    else $error("command queue full and empty at once");

  // Front end enqueues only into a queue with room
  a_no_wr_full: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> !cmdq_full)
    else $error("command written into full queue");

  // Execution unit dequeues only from a non-empty queue
  a_no_rd_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_rd |-> !cmdq_empty)
    else $error("command read from empty queue");

endmodule
